### hdl/inode_keyed_attr_hash_table_defines.svh
// Assertion macros shared by the hash table RTL.
`ifndef INODE_KEYED_ATTR_HASH_TABLE_DEFINES_SVH
`define INODE_KEYED_ATTR_HASH_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IKAHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IKAHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ikaht_pkg.sv
package ikaht_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 1024;
   localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

   localparam logic [31:0] START_MUL = 32'hB28E457D;
   localparam logic [31:0] STEP_MUL = 32'h53B23891;

   localparam logic [2:0] KIND_INSERT = 3'd0;
   localparam logic [2:0] KIND_GET = 3'd1;
   localparam logic [2:0] KIND_SET = 3'd2;
   localparam logic [2:0] KIND_INVALIDATE = 3'd3;
   localparam logic [2:0] KIND_CLEAR = 3'd4;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_ATTR_INVALID = 2'd2;
   localparam logic [1:0] STATUS_FULL = 2'd3;

   typedef struct packed {
      logic [2:0] kind;
      logic [31:0] inode;
      logic [55:0] attr_0;
      logic [55:0] attr_1;
      logic [55:0] attr_2;
      logic [55:0] attr_3;
      logic [55:0] attr_4;
   } ikaht_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [55:0] out_attr_0;
      logic [55:0] out_attr_1;
      logic [55:0] out_attr_2;
      logic [55:0] out_attr_3;
      logic [55:0] out_attr_4;
   } ikaht_rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [55:0] attr_0;
      logic [55:0] attr_1;
      logic [55:0] attr_2;
      logic [55:0] attr_3;
      logic [55:0] attr_4;
   } ikaht_entry_type;

endpackage

### hdl/inode_keyed_attr_hash_table.sv
// Each transaction is answered by a result strobe: a table operation after its probes, a table
// clear after it has swept every slot, and an unused kind straight from idle.
// A new transaction is accepted only after the last one is answered; two hash steps run on the
// shared multiplier, then each probe takes a registered read of the slot memories and the key compare.
// Reset is synchronous; afterwards a clearing pass over all TABLE_DEPTH slots empties the used-bit
// memory while busy is high. Configuration writes are taken during the pass.
`include "inode_keyed_attr_hash_table_defines.svh"

module inode_keyed_attr_hash_table
   import ikaht_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  ikaht_req_type req_data,
   output logic          rsp_valid,
   output ikaht_rsp_type rsp_data,
   input  logic          csr_we,
   input  logic [3:0]    csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int MAX_LOG2 = $clog2(TABLE_DEPTH + 1) - 1;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HASH_A = 3'd1;
   localparam logic [2:0] ST_HASH_B = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_SWEEP = 3'd5;

   logic [2:0] state_ff, state_in;
   ikaht_req_type req_ff, req_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic clr_rsp_ff, clr_rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   ikaht_rsp_type rsp_ff, rsp_in;
   logic [3:0] size_ff;

   logic used_mem [TABLE_DEPTH];
   ikaht_entry_type entry_mem [TABLE_DEPTH];
   logic used_rd_ff;
   ikaht_entry_type entry_rd_ff;

   logic used_we;
   logic [IDX_W-1:0] used_wa;
   logic used_wd;
   logic entry_we;
   ikaht_entry_type entry_wd;

   logic [4:0] size_eff;
   logic [IDX_W:0] slot_count;
   logic [IDX_W:0] mask_full;
   logic [IDX_W-1:0] mask;
   logic [31:0] mul_b;
   logic [31:0] mul_lo;
   logic key_hit;

   assign size_eff = ({1'b0, size_ff} > 5'(MAX_LOG2)) ? 5'(MAX_LOG2) : {1'b0, size_ff};
   assign slot_count = (IDX_W + 1)'(1) << size_eff;
   assign mask_full = slot_count - 1'b1;
   assign mask = mask_full[IDX_W-1:0];
   assign mul_lo = req_ff.inode * mul_b;
   assign key_hit = (entry_rd_ff.key == req_ff.inode);

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      idx_in = idx_ff;
      step_in = step_ff;
      count_in = count_ff;
      sweep_in = sweep_ff;
      clr_rsp_in = clr_rsp_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      mul_b = START_MUL;
      used_we = 1'b0;
      used_wa = idx_ff;
      used_wd = 1'b1;
      entry_we = 1'b0;
      entry_wd.key = req_ff.inode;
      entry_wd.attr_0 = req_ff.attr_0;
      entry_wd.attr_1 = req_ff.attr_1;
      entry_wd.attr_2 = req_ff.attr_2;
      entry_wd.attr_3 = req_ff.attr_3;
      entry_wd.attr_4 = req_ff.attr_4;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.kind == KIND_CLEAR) begin
                  state_in = ST_SWEEP;
                  sweep_in = '0;
                  clr_rsp_in = 1'b1;
               end else if (req_data.kind > KIND_INVALIDATE) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '0;
                  rsp_in.status = STATUS_OK;
               end else begin
                  state_in = ST_HASH_A;
                  count_in = '0;
               end
            end
         end
         ST_HASH_A: begin
            mul_b = START_MUL;
            idx_in = mul_lo[IDX_W-1:0] & mask;
            state_in = ST_HASH_B;
         end
         ST_HASH_B: begin
            mul_b = STEP_MUL;
            step_in = (mul_lo[IDX_W-1:0] & mask) | IDX_W'(1);
            state_in = ST_CHECK;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            rsp_in = '0;
            rsp_in.status = STATUS_OK;
            if (!used_rd_ff) begin
               if (req_ff.kind == KIND_INSERT) begin
                  used_we = 1'b1;
                  entry_we = 1'b1;
               end else begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else if (req_ff.kind != KIND_INSERT && key_hit) begin
               case (req_ff.kind)
                  KIND_GET: begin
                     if (entry_rd_ff.attr_0[55:48] != 8'd0) begin
                        rsp_in.out_attr_0 = entry_rd_ff.attr_0;
                        rsp_in.out_attr_1 = entry_rd_ff.attr_1;
                        rsp_in.out_attr_2 = entry_rd_ff.attr_2;
                        rsp_in.out_attr_3 = entry_rd_ff.attr_3;
                        rsp_in.out_attr_4 = entry_rd_ff.attr_4;
                     end else begin
                        rsp_in.status = STATUS_ATTR_INVALID;
                     end
                  end
                  KIND_SET: begin
                     entry_we = 1'b1;
                  end
                  default: begin
                     entry_we = 1'b1;
                     entry_wd.attr_0 = '0;
                     entry_wd.attr_1 = '0;
                     entry_wd.attr_2 = '0;
                     entry_wd.attr_3 = '0;
                     entry_wd.attr_4 = '0;
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else if (count_ff == mask) begin
               rsp_in.status = STATUS_FULL;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               idx_in = (idx_ff + step_ff) & mask;
               count_in = count_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_SWEEP: begin
            used_we = 1'b1;
            used_wa = sweep_ff;
            used_wd = 1'b0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '0;
                  rsp_in.status = STATUS_OK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         sweep_ff <= '0;
         clr_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         clr_rsp_ff <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_LOG2_RESET;
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
      step_ff <= step_in;
      count_ff <= count_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      used_rd_ff <= used_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[idx_ff] <= entry_wd;
      end
      entry_rd_ff <= entry_mem[idx_ff];
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `IKAHT_ASSERT_NEXT(a_accept_answered, clock, reset, start && !busy, busy || rsp_valid,
      "Accepted transaction was neither started nor answered.")
   `IKAHT_ASSERT_NOW(a_rsp_when_idle, clock, reset, rsp_valid, !busy,
      "Result strobe while the sequencer is still busy.")
   `IKAHT_ASSERT_NOW(a_fail_zero_attr, clock, reset,
      rsp_valid && rsp_data.status != STATUS_OK,
      rsp_data.out_attr_0 == '0 && rsp_data.out_attr_4 == '0,
      "Failed transaction returned nonzero attributes.")
   `IKAHT_ASSERT_NOW(a_probe_bound, clock, reset, state_ff == ST_CHECK, count_ff <= mask,
      "Probe count ran past one pass over the table.")

endmodule
